// ===== src/kfpi_pkg.sv =====
// Shared types and constants for the keyframe pose interpolator.
`timescale 1ns / 1ps

package kfpi_pkg;

    localparam int CHAN_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int STEPS_W  = 10;
    localparam int FRAMES_W = 7;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd190;

    // Request action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_STORE  = 2'd2;
    localparam logic [1:0] ACT_TOGGLE = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET,
        OP_STORE,
        OP_TOGGLE
    } op_t;

    typedef struct packed {
        logic [1:0]                action;
        logic [CHAN_W-1:0]         channel;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [CHAN_W-1:0]         out_channel;
        logic signed [VALUE_W-1:0] out_value;
        logic                      playing;
        logic [FRAMES_W-1:0]       stored_frames;
        logic                      last;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic               chan_ok;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } q_entry_t;

endpackage

// ===== src/kfpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kfpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/kfpi_div.sv =====
// Bit-serial signed-by-unsigned divider, truncating toward zero.
`timescale 1ns / 1ps

module kfpi_div
    import kfpi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [VALUE_W:0]   dividend,
    input  logic [STEPS_W-1:0]        divisor,
    output logic                      done,
    output logic [VALUE_W-1:0]        quotient
);

    localparam int MAG_W = VALUE_W + 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic               run_reg, run_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [STEPS_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0]   quo_reg, quo_next;
    logic [STEPS_W-1:0] den_reg, den_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic [VALUE_W-1:0] res_reg, res_next;

    logic [STEPS_W:0]   trial;
    logic               qbit;
    logic [MAG_W-1:0]   q_final;

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;

        trial   = {rem_reg, mag_reg[MAG_W-1]};
        qbit    = (trial >= {1'b0, den_reg});
        q_final = {quo_reg[MAG_W-2:0], qbit};

        if (start)
        begin
            // take the magnitude; -2^32 still fits in 33 unsigned bits
            run_next = 1'b1;
            cnt_next = CNT_W'(MAG_W);
            neg_next = dividend[VALUE_W];
            mag_next = dividend[VALUE_W] ? MAG_W'(-dividend) : MAG_W'(dividend);
            rem_next = '0;
            quo_next = '0;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = qbit ? STEPS_W'(trial - {1'b0, den_reg}) : trial[STEPS_W-1:0];
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            quo_next = q_final;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? VALUE_W'(-q_final[VALUE_W-1:0])
                                    : q_final[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

// ===== src/kfpi_front.sv =====
// Request front end: decode and classify requests into a two-entry queue.
`timescale 1ns / 1ps

module kfpi_front
    import kfpi_pkg::*;
#(
    parameter int CHANNELS = 11
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  cmd_t     cmd,
    output logic     q_valid,
    output q_entry_t q_entry,
    input  logic     q_pop
);

    q_entry_t   ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    q_entry_t   decoded;

    always_comb
    begin
        decoded.channel = cmd.channel;
        decoded.value   = cmd.value;
        decoded.chan_ok = ({1'b0, cmd.channel} < (CHAN_W + 1)'(CHANNELS));
        unique case (cmd.action)
            ACT_TICK:   decoded.op = OP_TICK;
            ACT_SET:    decoded.op = OP_SET;
            ACT_STORE:  decoded.op = OP_STORE;
            ACT_TOGGLE: decoded.op = OP_TOGGLE;
            default:    decoded.op = OP_TICK;
        endcase
    end

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_entry = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

// ===== src/kfpi_back.sv =====
// Execution sequencer: pose and increment registers, keyframe moves, readout.
`timescale 1ns / 1ps

module kfpi_back
    import kfpi_pkg::*;
#(
    parameter int CHANNELS      = 11,
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  q_entry_t             q_entry,
    output logic                 q_pop,
    input  logic [STEPS_W-1:0]   steps,
    output logic                 ram_we,
    output logic [(MAX_KEYFRAMES > 1 ? $clog2(MAX_KEYFRAMES) : 1)
                  + (CHANNELS > 1 ? $clog2(CHANNELS) : 1) - 1:0] ram_waddr,
    output logic [VALUE_W-1:0]   ram_wdata,
    output logic [(MAX_KEYFRAMES > 1 ? $clog2(MAX_KEYFRAMES) : 1)
                  + (CHANNELS > 1 ? $clog2(CHANNELS) : 1) - 1:0] ram_raddr,
    input  logic [VALUE_W-1:0]   ram_rdata,
    output logic                 div_start,
    output logic signed [VALUE_W:0] div_dividend,
    input  logic                 div_done,
    input  logic [VALUE_W-1:0]   div_quotient,
    output logic                 strobe,
    output result_t              result
);

    localparam int CH_W   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = MAX_KEYFRAMES > 1 ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int FC_W   = $clog2(MAX_KEYFRAMES + 1);
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_STORE   = 7'b0000010,
        S_RDA     = 7'b0000100,
        S_RDB     = 7'b0001000,
        S_DIVGO   = 7'b0010000,
        S_DIVWAIT = 7'b0100000,
        S_READ    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic                play_reg, play_next;
    logic [FC_W-1:0]     fc_reg, fc_next;
    logic [SLOT_W-1:0]   seg_reg, seg_next;
    logic [STEPS_W-1:0]  step_reg, step_next;
    logic                add_reg, add_next;
    logic                load_reg, load_next;
    logic                strobe_reg, strobe_next;
    result_t             result_reg, result_next;
    logic [VALUE_W-1:0]  a_reg, a_next;
    logic [VALUE_W-1:0]  pose_reg [CHANNELS];
    logic [VALUE_W-1:0]  pose_next [CHANNELS];
    logic [VALUE_W-1:0]  inc_reg [CHANNELS];
    logic [VALUE_W-1:0]  inc_next [CHANNELS];

    logic [FC_W-1:0]     seg_adv;
    logic [FC_W:0]       seg_plus2;
    logic [SLOT_W-1:0]   seg_p1;
    logic [VALUE_W-1:0]  read_val;

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        play_next   = play_reg;
        fc_next     = fc_reg;
        seg_next    = seg_reg;
        step_next   = step_reg;
        add_next    = add_reg;
        load_next   = load_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        a_next      = a_reg;
        pose_next   = pose_reg;
        inc_next    = inc_reg;

        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = {SLOT_W'(fc_reg), ch_reg};
        ram_wdata    = pose_reg[ch_reg];
        seg_p1       = seg_reg + SLOT_W'(1);
        ram_raddr    = {seg_reg, ch_reg};
        div_start    = 1'b0;
        div_dividend = {ram_rdata[VALUE_W-1], ram_rdata} - {a_reg[VALUE_W-1], a_reg};

        seg_adv   = FC_W'(seg_reg) + FC_W'(1);
        seg_plus2 = {1'b0, seg_adv} + (FC_W + 1)'(2);
        read_val  = add_reg ? pose_reg[ch_reg] + inc_reg[ch_reg] : pose_reg[ch_reg];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ch_next    = '0;
                    state_next = S_READ;
                    unique case (q_entry.op)
                        OP_TICK:
                        begin
                            if (play_reg)
                            begin
                                if (step_reg >= steps)
                                begin
                                    // segment end: advance without moving
                                    if (seg_plus2 > {1'b0, fc_reg})
                                    begin
                                        seg_next  = '0;
                                        play_next = 1'b0;
                                    end
                                    else
                                    begin
                                        seg_next   = SLOT_W'(seg_adv);
                                        step_next  = '0;
                                        load_next  = 1'b0;
                                        state_next = S_RDA;
                                    end
                                end
                                else
                                begin
                                    add_next  = 1'b1;
                                    step_next = step_reg + STEPS_W'(1);
                                end
                            end
                        end
                        OP_SET:
                        begin
                            if (q_entry.chan_ok)
                            begin
                                pose_next[CH_W'(q_entry.channel)] = q_entry.value;
                            end
                        end
                        OP_STORE:
                        begin
                            if (fc_reg < FC_W'(MAX_KEYFRAMES))
                            begin
                                state_next = S_STORE;
                            end
                        end
                        OP_TOGGLE:
                        begin
                            if (!play_reg && fc_reg > FC_W'(1))
                            begin
                                seg_next   = '0;
                                step_next  = '0;
                                play_next  = 1'b1;
                                load_next  = 1'b1;
                                state_next = S_RDA;
                            end
                            else
                            begin
                                play_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_STORE:
            begin
                ram_we = 1'b1;
                if (ch_reg == LAST_CH)
                begin
                    ch_next    = '0;
                    fc_next    = fc_reg + FC_W'(1);
                    state_next = S_READ;
                end
                else
                begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            S_RDA:
            begin
                ram_raddr  = {seg_reg, ch_reg};
                state_next = S_RDB;
            end
            S_RDB:
            begin
                ram_raddr = {seg_p1, ch_reg};
                a_next    = ram_rdata;
                if (load_reg)
                begin
                    pose_next[ch_reg] = ram_rdata;
                end
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (div_done)
                begin
                    inc_next[ch_reg] = div_quotient;
                    if (ch_reg == LAST_CH)
                    begin
                        ch_next    = '0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_RDA;
                    end
                end
            end
            S_READ:
            begin
                pose_next[ch_reg]         = read_val;
                strobe_next               = 1'b1;
                result_next.out_channel   = CHAN_W'(ch_reg);
                result_next.out_value     = read_val;
                result_next.playing       = play_reg;
                result_next.stored_frames = FRAMES_W'(fc_reg);
                result_next.last          = (ch_reg == LAST_CH);
                if (ch_reg == LAST_CH)
                begin
                    ch_next    = '0;
                    add_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ch_reg     <= '0;
            play_reg   <= 1'b0;
            fc_reg     <= '0;
            seg_reg    <= '0;
            step_reg   <= '0;
            add_reg    <= 1'b0;
            load_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pose_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            play_reg   <= play_next;
            fc_reg     <= fc_next;
            seg_reg    <= seg_next;
            step_reg   <= step_next;
            add_reg    <= add_next;
            load_reg   <= load_next;
            strobe_reg <= strobe_next;
            pose_reg   <= pose_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        a_reg      <= a_next;
        inc_reg    <= inc_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== src/keyframe_pose_interpolator.sv =====
// Top level of the keyframe pose interpolator: config register and unit wiring.
`timescale 1ns / 1ps
//
//  Channel   Signals                Transfer
//  -------   --------------------   ------------------------------------------
//  request   start, busy, cmd       taken on a clock edge with start high, busy low
//  result    strobe, result         one result per cycle, cannot be held off
//  config    cfg_we, cfg_wdata      steps_per_segment, written when cfg_we is high
//
//  Every request yields CHANNELS results on consecutive cycles, channel 0 first.
//  Set, tick and a refused toggle go straight to the readout once the back end
//  takes them; a store first copies the pose into keyframe RAM. Starting playback
//  or crossing a segment recomputes the increments one channel at a time through
//  the serial divider before the readout.
//  Reset clears pose, playback state and the frame count; stored keyframes stay
//  undefined until written. Busy rises once two requests wait in the queue.
//
module keyframe_pose_interpolator
    import kfpi_pkg::*;
#(
    parameter int CHANNELS      = 11,
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cmd_t               cmd,
    input  logic               cfg_we,
    input  logic [STEPS_W-1:0] cfg_wdata,
    output logic               strobe,
    output result_t            result
);

    // Keyframe RAM holds one row per slot, the channel index in the low bits.
    localparam int CH_W   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = MAX_KEYFRAMES > 1 ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int ADDR_W = SLOT_W + CH_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic [STEPS_W-1:0]  steps_reg;
    logic [STEPS_W-1:0]  steps_eff;

    logic                q_valid;
    q_entry_t            q_entry;
    logic                q_pop;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    logic                div_start;
    logic signed [VALUE_W:0] div_dividend;
    logic                div_done;
    logic [VALUE_W-1:0]  div_quotient;

    // Hold the step count; a zero setting behaves as a single step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEPS_RESET;
        end
        else if (cfg_we)
        begin
            steps_reg <= cfg_wdata;
        end
    end

    assign steps_eff = (steps_reg == '0) ? STEPS_W'(1) : steps_reg;

    // Front: take requests, classify the action, queue them.
    kfpi_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    // Back: carry out the queued request and stream the pose readout.
    kfpi_back #(
        .CHANNELS      (CHANNELS),
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .steps        (steps_eff),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .strobe       (strobe),
        .result       (result)
    );

    kfpi_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared serial divider for the per-channel increments.
    kfpi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (steps_eff),
        .done     (div_done),
        .quotient (div_quotient)
    );

endmodule

// ===== tb/sv/kfpi_readout_checker.sv =====
// Predicts the per-request channel readout of the keyframe pose interpolator and compares it.
`timescale 1ns / 1ps

module kfpi_readout_checker
    import kfpi_pkg::*;
#(
    parameter int CHANNELS      = 11,
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  cmd_t               cmd,
    input  logic               cfg_we,
    input  logic [STEPS_W-1:0] cfg_wdata,
    input  logic               strobe,
    input  result_t            result,
    output int                 fail_count,
    output int                 outstanding
);

    logic [VALUE_W-1:0] pose      [CHANNELS];
    logic [VALUE_W-1:0] increment [CHANNELS];
    logic [VALUE_W-1:0] keyframes [MAX_KEYFRAMES][CHANNELS];
    logic [STEPS_W-1:0] steps_cfg;
    logic               playing;
    int                 frame_count;
    int                 seg;
    int                 step;
    int                 failures;
    result_t            readout_q [$];

    function automatic longint active_steps();
        return (steps_cfg == '0) ? 64'sd1 : longint'(steps_cfg);
    endfunction

    // Per-channel slope of the current segment, truncated toward zero.
    function automatic void derive_increments();
        longint span;
        longint quotient;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (seg + 1 >= MAX_KEYFRAMES)
            begin
                increment[c] = '0;
            end
            else
            begin
                span = longint'($signed(keyframes[seg + 1][c]))
                     - longint'($signed(keyframes[seg][c]));
                quotient = span / active_steps();
                increment[c] = quotient[VALUE_W-1:0];
            end
        end
    endfunction

    function automatic void advance_pose(cmd_t req);
        case (op_t'(req.action))
            OP_TICK:
            begin
                if (playing)
                begin
                    if (longint'(step) >= active_steps())
                    begin
                        seg++;
                        if (seg + 2 > frame_count)
                        begin
                            seg = 0;
                            playing = 1'b0;
                        end
                        else
                        begin
                            step = 0;
                            derive_increments();
                        end
                    end
                    else
                    begin
                        for (int c = 0; c < CHANNELS; c++)
                            pose[c] = pose[c] + increment[c];
                        step++;
                    end
                end
            end
            OP_SET:
            begin
                if (req.channel < CHANNELS)
                    pose[req.channel] = req.value;
            end
            OP_STORE:
            begin
                if (frame_count < MAX_KEYFRAMES)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                        keyframes[frame_count][c] = pose[c];
                    frame_count++;
                end
            end
            OP_TOGGLE:
            begin
                if (!playing && frame_count > 1)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                        pose[c] = keyframes[0][c];
                    seg = 0;
                    step = 0;
                    derive_increments();
                    playing = 1'b1;
                end
                else
                begin
                    playing = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic void queue_readout();
        result_t r;
        for (int c = 0; c < CHANNELS; c++)
        begin
            r.out_channel   = CHAN_W'(c);
            r.out_value     = pose[c];
            r.playing       = playing;
            r.stored_frames = FRAMES_W'(frame_count);
            r.last          = (c == CHANNELS - 1);
            readout_q.push_back(r);
        end
    endfunction

    function automatic int field_mismatch(input string name, input logic [VALUE_W-1:0] want,
                                          input logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                pose[c]      = '0;
                increment[c] = '0;
            end
            steps_cfg   = STEPS_RESET;
            playing     = 1'b0;
            frame_count = 0;
            seg         = 0;
            step        = 0;
            failures    = 0;
            readout_q.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (readout_q.size() == 0)
                begin
                    $error("result on channel %0d with no readout pending", result.out_channel);
                    failures++;
                end
                else
                begin
                    want = readout_q.pop_front();
                    failures += field_mismatch("out_channel", want.out_channel,
                                               result.out_channel);
                    failures += field_mismatch("out_value", want.out_value, result.out_value);
                    failures += field_mismatch("playing", want.playing, result.playing);
                    failures += field_mismatch("stored_frames", want.stored_frames,
                                               result.stored_frames);
                    failures += field_mismatch("last", want.last, result.last);
                end
            end
            if (start && !busy)
            begin
                advance_pose(cmd);
                queue_readout();
            end
            if (cfg_we)
                steps_cfg = cfg_wdata;
        end
        fail_count  <= failures;
        outstanding <= readout_q.size();
    end

endmodule

// ===== tb/sv/keyframe_pose_interpolator_tb.sv =====
// Stimulus, clock, reset and verdict for the keyframe pose interpolator.
`timescale 1ns / 1ps

module keyframe_pose_interpolator_tb;
    import kfpi_pkg::*;

    localparam int CHANNELS      = 11;
    localparam int MAX_KEYFRAMES = 64;
    // Idle margin after the last readout; the block has no work left by then.
    localparam int SETTLE_CYCLES = 600;
    // Cycles with no request, result or register write before the run is abandoned.
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 16;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    cmd_t               cmd       = '0;
    logic               cfg_we    = 1'b0;
    logic [STEPS_W-1:0] cfg_wdata = '0;
    logic               busy;
    logic               strobe;
    result_t            result;
    int                 fail_count;
    int                 outstanding;
    int                 quiet_cycles = 0;
    int                 sent         = 0;
    bit                 gaps_on      = 1'b1;

    always #5 clk = ~clk;

    keyframe_pose_interpolator #(
        .CHANNELS      (CHANNELS),
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .strobe    (strobe),
        .result    (result)
    );

    kfpi_readout_checker #(
        .CHANNELS      (CHANNELS),
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) readout_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .strobe      (strobe),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Reset any time something moves; give up once the block has gone quiet for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // Lean on the wrap-around corners every so often.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Hold the request until it is taken, then either follow straight on or idle.
    task automatic send_request(input op_t op, input logic [CHAN_W-1:0] ch,
                                input logic [VALUE_W-1:0] val);
        cmd_t req;
        int   gap;
        req.action  = op;
        req.channel = ch;
        req.value   = val;
        start <= 1'b1;
        cmd   <= req;
        do
            @(posedge clk);
        while (busy);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd   <= cmd_t'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_random_channel();
        send_request(OP_SET, CHAN_W'($urandom_range(0, CHANNELS - 1)), pick_value());
    endtask

    // Drop start, let every readout arrive, then idle a while before moving on.
    task automatic drain_readouts();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_steps(input logic [STEPS_W-1:0] steps);
        drain_readouts();
        cfg_we    <= 1'b1;
        cfg_wdata <= steps;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Build a keyframe or two, start playback and tick through some segments.
    task automatic play_episode();
        int keys;
        int touches;
        int ticks;
        keys = $urandom_range(1, 2);
        repeat (keys)
        begin
            touches = $urandom_range(0, 3);
            repeat (touches) set_random_channel();
            send_request(OP_STORE, CHAN_W'($urandom), $urandom);
        end
        send_request(OP_TOGGLE, CHAN_W'($urandom), $urandom);
        ticks = $urandom_range(1, 10);
        repeat (ticks) send_request(OP_TICK, CHAN_W'($urandom), $urandom);
        if ($urandom_range(0, 2) == 0)
            send_request(OP_TOGGLE, CHAN_W'($urandom), $urandom);
    endtask

    // Raw request: any action, any channel including the unused ones.
    task automatic send_noise();
        send_request(op_t'($urandom_range(0, 3)), CHAN_W'($urandom), pick_value());
    endtask

    task automatic random_phase(input logic [STEPS_W-1:0] steps, input bit with_gaps);
        int phase_end;
        write_steps(steps);
        gaps_on   = with_gaps;
        phase_end = sent + PHASE_ITEMS;
        while (sent < phase_end)
        begin
            if ($urandom_range(0, 99) < 80)
                play_episode();
            else
                send_noise();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Zero steps behaves as a single step per segment.
        write_steps('0);

        // Tick with nothing playing, then the channel extremes and ignored channels.
        send_request(OP_TICK, 4'd0, 32'h0000_0000);
        send_request(OP_SET, 4'd0, 32'h7FFF_FFFF);
        send_request(OP_SET, 4'd10, 32'h8000_0000);
        send_request(OP_SET, 4'd11, 32'h1234_5678);
        send_request(OP_SET, 4'd15, 32'hFFFF_FFFF);
        // Playback refused with no keyframe and with a single one.
        send_request(OP_TOGGLE, 4'd0, 32'h0);
        send_request(OP_STORE, 4'd0, 32'h0);
        send_request(OP_TOGGLE, 4'd0, 32'h0);
        // Opposite extremes in the second keyframe give the widest differences.
        send_request(OP_SET, 4'd0, 32'h8000_0000);
        send_request(OP_SET, 4'd10, 32'h7FFF_FFFF);
        send_request(OP_SET, 4'd5, 32'hFFFF_FFFF);
        send_request(OP_STORE, 4'd0, 32'h0);
        send_request(OP_TOGGLE, 4'd0, 32'h0);
        send_request(OP_TICK, 4'd0, 32'h0);
        // Store while playing, then cross into the new segment and run off the end.
        send_request(OP_STORE, 4'd0, 32'h0);
        send_request(OP_TICK, 4'd0, 32'h0);
        send_request(OP_TICK, 4'd0, 32'h0);
        send_request(OP_TICK, 4'd0, 32'h0);
        send_request(OP_TICK, 4'd0, 32'h0);
        // Start, stop and restart from the first keyframe, then edit mid-play.
        send_request(OP_TOGGLE, 4'd0, 32'h0);
        send_request(OP_TOGGLE, 4'd0, 32'h0);
        send_request(OP_TOGGLE, 4'd0, 32'h0);
        send_request(OP_SET, 4'd3, 32'h0001_8000);

        random_phase(10'd1, 1'b1);
        random_phase(10'd1023, 1'b1);
        random_phase(10'd2, 1'b0);

        // Fill the keyframe store to capacity and push past it.
        write_steps(10'd1);
        gaps_on = 1'b1;
        repeat (62)
        begin
            if ($urandom_range(0, 3) == 0)
                set_random_channel();
            send_request(OP_STORE, CHAN_W'($urandom), $urandom);
        end

        random_phase(10'd1, 1'b1);
        random_phase(10'd4, 1'b0);
        random_phase(STEPS_W'($urandom_range(1, 1023)), 1'b1);

        drain_readouts();
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/kfpi_pkg.sv
src/kfpi_ram.sv
src/kfpi_div.sv
src/kfpi_front.sv
src/kfpi_back.sv
src/keyframe_pose_interpolator.sv
tb/sv/kfpi_readout_checker.sv
tb/sv/keyframe_pose_interpolator_tb.sv
